[hw/rtl/lcd_scanline_timing_controller_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scan-line timing controller
// Clocked assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef LCD_SCANLINE_TIMING_CONTROLLER_ASSERT_SVH
`define LCD_SCANLINE_TIMING_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define LCDST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lcdst: assertion failed");
// Checked at every edge, reset included.
`define LCDST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("lcdst: assertion failed");
`else
`define LCDST_ASSERT(lbl, prop)
`define LCDST_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[hw/rtl/lcdst_pkg.sv]
// ----------------------------------------------------------------------------
// lcdst_pkg
// Types and constants shared by the scan-line timing controller modules.
// ----------------------------------------------------------------------------
package lcdst_pkg;

  // Line timing
  localparam logic [9:0] LINE_CYCLES   = 10'd456;
  localparam logic [9:0] OAM_DOTS      = 10'd80;
  localparam logic [9:0] XFER_DOTS     = 10'd172;
  localparam logic [9:0] OAM_BOUND     = LINE_CYCLES - OAM_DOTS;
  localparam logic [9:0] XFER_BOUND    = OAM_BOUND - XFER_DOTS;
  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [7:0] LAST_LINE     = 8'd153;

  // Display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Bits of the status interrupt enable register
  localparam int IRQ_EN_HBLANK = 0;
  localparam int IRQ_EN_VBLANK = 1;
  localparam int IRQ_EN_OAM    = 2;
  localparam int IRQ_EN_COIN   = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_LCD_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_IDX_LINE_COMPARE = 2'd1;
  localparam logic [1:0] CFG_IDX_STAT_IRQ_EN  = 2'd2;

  typedef struct packed {
    logic       lcd_enable;
    logic [7:0] line_compare;
    logic [3:0] stat_irq_enables;
  } cfg_t;

  typedef struct packed {
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_line;
    logic [7:0] line_number;
    logic [1:0] lcd_mode;
    logic       coincidence;
  } res_t;

endpackage

[hw/rtl/lcdst_cfg.sv]
// ----------------------------------------------------------------------------
// lcdst_cfg
// Configuration registers of the scan-line timing controller.
// ----------------------------------------------------------------------------
module lcdst_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output lcdst_pkg::cfg_t   cfg
);

  lcdst_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lcdst_pkg::CFG_IDX_LCD_ENABLE:   cfg_r.lcd_enable       <= cfg_wdata[0];
        lcdst_pkg::CFG_IDX_LINE_COMPARE: cfg_r.line_compare     <= cfg_wdata;
        lcdst_pkg::CFG_IDX_STAT_IRQ_EN:  cfg_r.stat_irq_enables <= cfg_wdata[3:0];
        default: begin
          // Unused index: write is dropped.
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/lcdst_timing.sv]
// ----------------------------------------------------------------------------
// lcdst_timing
// Dot counter, line counter, mode and coincidence state with the step logic.
// ----------------------------------------------------------------------------
module lcdst_timing (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  lcdst_pkg::cfg_t cfg,
  input  logic [7:0]      cycles,
  output lcdst_pkg::res_t res
);

  logic [9:0]        dot_counter_r, dot_counter_nxt;
  logic [7:0]        current_line_r, current_line_nxt;
  logic [1:0]        mode_bits_r, mode_bits_nxt;
  logic              coin_r, coin_nxt;

  logic [1:0]        new_mode;
  logic              want;
  logic [7:0]        line_inc;
  logic signed [10:0] diff_s;
  logic signed [11:0] reload_s;
  logic              expired;
  logic [9:0]        reload;

  // Counter after this step; eleven bits hold the signed result.
  assign diff_s   = $signed({1'b0, dot_counter_r}) - $signed({3'b000, cycles});
  assign expired  = diff_s[10] || (diff_s == 11'sd0);
  assign reload_s = $signed({2'b00, lcdst_pkg::LINE_CYCLES}) + $signed({diff_s[10], diff_s});
  assign reload   = reload_s[11] ? 10'd0 : reload_s[9:0];
  assign line_inc = current_line_r + 8'd1;

  always_comb begin
    dot_counter_nxt  = dot_counter_r;
    current_line_nxt = current_line_r;
    mode_bits_nxt    = mode_bits_r;
    coin_nxt         = coin_r;
    new_mode         = lcdst_pkg::MODE_HBLANK;
    want             = 1'b0;
    res.vblank_irq   = 1'b0;
    res.stat_irq     = 1'b0;
    res.draw_line    = 1'b0;

    if (!cfg.lcd_enable) begin
      dot_counter_nxt  = lcdst_pkg::LINE_CYCLES;
      current_line_nxt = 8'd0;
      mode_bits_nxt    = lcdst_pkg::MODE_VBLANK;
    end else begin
      // Mode from the state before the count-down.
      if (current_line_r >= lcdst_pkg::VISIBLE_LINES) begin
        new_mode      = lcdst_pkg::MODE_VBLANK;
        mode_bits_nxt = lcdst_pkg::MODE_VBLANK;
        want          = cfg.stat_irq_enables[lcdst_pkg::IRQ_EN_VBLANK];
      end else if (dot_counter_r != 10'd0) begin
        if (dot_counter_r >= lcdst_pkg::OAM_BOUND) begin
          new_mode = lcdst_pkg::MODE_OAM;
          want     = cfg.stat_irq_enables[lcdst_pkg::IRQ_EN_OAM];
        end else if (dot_counter_r >= lcdst_pkg::XFER_BOUND) begin
          new_mode = lcdst_pkg::MODE_XFER;
        end else begin
          new_mode = lcdst_pkg::MODE_HBLANK;
          want     = cfg.stat_irq_enables[lcdst_pkg::IRQ_EN_HBLANK];
        end
        mode_bits_nxt = new_mode;
      end
      res.stat_irq = want && (mode_bits_r != new_mode);

      if (current_line_r == cfg.line_compare) begin
        coin_nxt = 1'b1;
        if (cfg.stat_irq_enables[lcdst_pkg::IRQ_EN_COIN]) begin
          res.stat_irq = 1'b1;
        end
      end else begin
        coin_nxt = 1'b0;
      end

      if (expired) begin
        dot_counter_nxt  = reload;
        current_line_nxt = line_inc;
        // Lines after the first invisible one up to the last raise nothing.
        if (line_inc == lcdst_pkg::VISIBLE_LINES) begin
          res.vblank_irq = 1'b1;
        end else if (line_inc > lcdst_pkg::LAST_LINE) begin
          current_line_nxt = 8'd0;
          res.draw_line    = 1'b1;
        end else if (line_inc < lcdst_pkg::VISIBLE_LINES) begin
          res.draw_line = 1'b1;
        end
      end else begin
        dot_counter_nxt = diff_s[9:0];
      end
    end

    res.line_number = current_line_nxt;
    res.lcd_mode    = mode_bits_nxt;
    res.coincidence = coin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_counter_r  <= 10'd0;
      current_line_r <= 8'd0;
      mode_bits_r    <= lcdst_pkg::MODE_HBLANK;
      coin_r         <= 1'b0;
    end else if (step_en) begin
      dot_counter_r  <= dot_counter_nxt;
      current_line_r <= current_line_nxt;
      mode_bits_r    <= mode_bits_nxt;
      coin_r         <= coin_nxt;
    end
  end

endmodule

[hw/rtl/lcd_scanline_timing_controller.sv]
// ----------------------------------------------------------------------------
// lcd_scanline_timing_controller
// Display scan-line timing: mode, line count and interrupt requests per item.
// ----------------------------------------------------------------------------
// Each input item carries the number of clock cycles that have elapsed since
// the previous one. For every item the block returns exactly one result item
// with the vertical blank and status interrupt requests, the line-draw strobe,
// the line number, the display mode and the coincidence flag after the step.
// Both channels use valid and stall; an item moves at an edge where valid is
// high and stall is low. The configuration port writes one register per edge.
// The user writes it only while the block is idle; the block does not enforce
// this. Index 0 is display enable, 1 line compare, 2 status interrupt enables.
// An accepted item lands in an input register; while the result register is
// free or being emptied, the step logic updates the timing state from it and
// loads the result register, which offers the result to the receiver.
// One item is taken every cycle while the receiver does not stall; the state
// update between the input and result registers sets this sustained rate.
// When the receiver stalls, the result register holds its item, the input
// register still takes one further item, and then in_stall is raised until
// the result is taken. Reset clears both registers, the timing state and the
// configuration, which leaves the display disabled.
// ----------------------------------------------------------------------------
`include "lcd_scanline_timing_controller_assert.svh"

module lcd_scanline_timing_controller (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_elapsed_cycles,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_vblank_irq,
  output logic       out_stat_irq,
  output logic       out_draw_line,
  output logic [7:0] out_line_number,
  output logic [1:0] out_lcd_mode,
  output logic       out_coincidence,
  // Configuration port
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  lcdst_pkg::cfg_t cfg;
  lcdst_pkg::res_t res;
  lcdst_pkg::res_t res_r;

  logic       in_valid_r;
  logic [7:0] in_cycles_r;
  logic       out_valid_r;
  logic       in_accept;
  logic       advance;

  // The held item steps forward whenever the result register is free or is
  // being emptied in this very cycle.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  lcdst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcdst_timing u_timing (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cfg     (cfg),
    .cycles  (in_cycles_r),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_cycles_r <= in_elapsed_cycles;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vblank_irq  = res_r.vblank_irq;
  assign out_stat_irq    = res_r.stat_irq;
  assign out_draw_line   = res_r.draw_line;
  assign out_line_number = res_r.line_number;
  assign out_lcd_mode    = res_r.lcd_mode;
  assign out_coincidence = res_r.coincidence;

  // A vertical blank step never also asks for a line to be drawn.
  `LCDST_ASSERT(a_vblank_no_draw, out_valid_r |-> !(res_r.vblank_irq && res_r.draw_line))
  // Vertical blank is raised only on entry to the first invisible line.
  `LCDST_ASSERT(a_vblank_line, (out_valid_r && res_r.vblank_irq) |-> (res_r.line_number == lcdst_pkg::VISIBLE_LINES))
  // The line count wraps past the last line.
  `LCDST_ASSERT(a_line_range, out_valid_r |-> (res_r.line_number <= lcdst_pkg::LAST_LINE))
  // Input back-pressure only comes from a full, stalled result register.
  `LCDST_ASSERT(a_stall_cause, in_stall |-> (out_valid_r && out_stall && in_valid_r))
  // Reset empties the result register.
  `LCDST_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r)

endmodule

[verif/lcd_scanline_timing_controller_checker.sv]
// ----------------------------------------------------------------------------
// Scan-line timing checker
// Watches the configuration port and both channels of the timing controller,
// predicts one status item per accepted input item and compares them.
// ----------------------------------------------------------------------------
module lcd_scanline_timing_controller_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_elapsed_cycles,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_vblank_irq,
  input  logic       out_stat_irq,
  input  logic       out_draw_line,
  input  logic [7:0] out_line_number,
  input  logic [1:0] out_lcd_mode,
  input  logic       out_coincidence,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         mismatch_count,
  output int         status_pending
);

  // Local copy of the configuration and timing state.
  logic       lcd_on;
  logic [7:0] line_cmp;
  logic [3:0] irq_en;
  int         dot_count;
  logic [7:0] scan_line;
  logic [1:0] mode_reg;
  logic       coin_flag;

  lcdst_pkg::res_t status_due_q[$];
  int              errors;

  initial begin
    mismatch_count = 0;
    status_pending = 0;
    errors         = 0;
  end

  // One timing step: mode from the old counter, then count down and advance.
  function automatic lcdst_pkg::res_t advance_scanline(input logic [7:0] cycles);
    lcdst_pkg::res_t r;
    logic [1:0]      prev_mode;
    logic [1:0]      next_mode;
    logic            mode_irq_on;
    int              dots;
    int              reload;
    r = '0;
    if (!lcd_on) begin
      dot_count = int'(lcdst_pkg::LINE_CYCLES);
      scan_line = 8'd0;
      mode_reg  = lcdst_pkg::MODE_VBLANK;
    end else begin
      prev_mode   = mode_reg;
      next_mode   = lcdst_pkg::MODE_HBLANK;
      mode_irq_on = 1'b0;
      if (scan_line >= lcdst_pkg::VISIBLE_LINES) begin
        next_mode   = lcdst_pkg::MODE_VBLANK;
        mode_reg    = lcdst_pkg::MODE_VBLANK;
        mode_irq_on = irq_en[lcdst_pkg::IRQ_EN_VBLANK];
      end else if (dot_count != 0) begin
        if (dot_count >= int'(lcdst_pkg::OAM_BOUND)) begin
          next_mode   = lcdst_pkg::MODE_OAM;
          mode_irq_on = irq_en[lcdst_pkg::IRQ_EN_OAM];
        end else if (dot_count >= int'(lcdst_pkg::XFER_BOUND)) begin
          next_mode   = lcdst_pkg::MODE_XFER;
        end else begin
          next_mode   = lcdst_pkg::MODE_HBLANK;
          mode_irq_on = irq_en[lcdst_pkg::IRQ_EN_HBLANK];
        end
        mode_reg = next_mode;
      end
      if (mode_irq_on && prev_mode != next_mode) begin
        r.stat_irq = 1'b1;
      end

      coin_flag = (scan_line == line_cmp);
      if (coin_flag && irq_en[lcdst_pkg::IRQ_EN_COIN]) begin
        r.stat_irq = 1'b1;
      end

      dots = dot_count - int'(cycles);
      if (dots <= 0) begin
        reload = int'(lcdst_pkg::LINE_CYCLES) + dots;
        if (reload < 0) begin
          reload = 0;
        end
        dot_count = reload & 'h3FF;
        scan_line = scan_line + 8'd1;
        if (scan_line == lcdst_pkg::VISIBLE_LINES) begin
          r.vblank_irq = 1'b1;
        end else if (scan_line > lcdst_pkg::LAST_LINE) begin
          scan_line   = 8'd0;
          r.draw_line = 1'b1;
        end else if (scan_line < lcdst_pkg::VISIBLE_LINES) begin
          r.draw_line = 1'b1;
        end
      end else begin
        dot_count = dots;
      end
    end
    r.line_number = scan_line;
    r.lcd_mode    = mode_reg;
    r.coincidence = coin_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    lcdst_pkg::res_t seen;
    lcdst_pkg::res_t want;
    if (!rst_n) begin
      lcd_on    = 1'b0;
      line_cmp  = 8'd0;
      irq_en    = 4'd0;
      dot_count = 0;
      scan_line = 8'd0;
      mode_reg  = lcdst_pkg::MODE_HBLANK;
      coin_flag = 1'b0;
      status_due_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          lcdst_pkg::CFG_IDX_LCD_ENABLE:   lcd_on   = cfg_wdata[0];
          lcdst_pkg::CFG_IDX_LINE_COMPARE: line_cmp = cfg_wdata;
          lcdst_pkg::CFG_IDX_STAT_IRQ_EN:  irq_en   = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        status_due_q.push_back(advance_scanline(in_elapsed_cycles));
      end
      if (out_valid && !out_stall) begin
        seen = '{out_vblank_irq, out_stat_irq, out_draw_line, out_line_number,
                 out_lcd_mode, out_coincidence};
        if (status_due_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: status item arrived with none expected", $time);
          end
        end else begin
          want = status_due_q.pop_front();
          if (seen.vblank_irq  !== want.vblank_irq  ||
              seen.stat_irq    !== want.stat_irq    ||
              seen.draw_line   !== want.draw_line   ||
              seen.line_number !== want.line_number ||
              seen.lcd_mode    !== want.lcd_mode    ||
              seen.coincidence !== want.coincidence) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp vbl=%0b stat=%0b draw=%0b ly=%0d mode=%0d coin=%0b",
                       $time, want.vblank_irq, want.stat_irq, want.draw_line,
                       want.line_number, want.lcd_mode, want.coincidence);
              $display("%0t:          got vbl=%0b stat=%0b draw=%0b ly=%0d mode=%0d coin=%0b",
                       $time, seen.vblank_irq, seen.stat_irq, seen.draw_line,
                       seen.line_number, seen.lcd_mode, seen.coincidence);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    status_pending <= status_due_q.size();
  end

endmodule

[verif/lcd_scanline_timing_controller_tb.sv]
// ----------------------------------------------------------------------------
// Scan-line timing controller testbench
// Drives elapsed-cycle items through the controller under several register
// settings with random idling on both channels; a checker beside the block
// predicts every status item and this module gives the verdict.
// ----------------------------------------------------------------------------
module lcd_scanline_timing_controller_tb;

  // The port allows index 3, which names no register; writes to it must be
  // ignored by the block.
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;
  // Far above the slowest plausible run of about 1700 items with idling.
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_elapsed_cycles;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_vblank_irq;
  logic       out_stat_irq;
  logic       out_draw_line;
  logic [7:0] out_line_number;
  logic [1:0] out_lcd_mode;
  logic       out_coincidence;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  int mismatch_count;
  int status_pending;
  int cycle_count = 0;
  // Cleared for a stretch of the run so that both sides go flat out.
  bit gaps_on = 1'b1;

  always #4 clk = ~clk;

  lcd_scanline_timing_controller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_elapsed_cycles (in_elapsed_cycles),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vblank_irq    (out_vblank_irq),
    .out_stat_irq      (out_stat_irq),
    .out_draw_line     (out_draw_line),
    .out_line_number   (out_line_number),
    .out_lcd_mode      (out_lcd_mode),
    .out_coincidence   (out_coincidence),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  lcd_scanline_timing_controller_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_elapsed_cycles (in_elapsed_cycles),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vblank_irq    (out_vblank_irq),
    .out_stat_irq      (out_stat_irq),
    .out_draw_line     (out_draw_line),
    .out_line_number   (out_line_number),
    .out_lcd_mode      (out_lcd_mode),
    .out_coincidence   (out_coincidence),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .status_pending    (status_pending)
  );

  // The receiver stalls in roughly a third of the cycles while idling is on.
  // The stall is a fresh draw each edge, so it lands on every pipeline phase.
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 32);
  end

  // Watchdog: a hung handshake or a lost status item ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one item and returns at the edge that accepts it. Idle cycles are
  // only ever inserted before the item is offered, so once valid is up it
  // stays up with a steady payload until the block takes it.
  task automatic send_item(input logic [7:0] cycles);
    while (gaps_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_elapsed_cycles <= cycles;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering items and waits until every status item has come back.
  // The pending count is registered in the checker, so the task first waits at
  // a clock edge to let it see the last accepted item.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_pending != 0) @(posedge clk);
  endtask

  // Writes all three registers and then the unused index. Bits above the enable
  // and interrupt enable fields carry random values, which the block must drop.
  task automatic program_timing(input logic en, input logic [7:0] cmp,
                                input logic [3:0] irq);
    cfg_wr_en <= 1'b1;
    cfg_index <= lcdst_pkg::CFG_IDX_LCD_ENABLE;
    cfg_wdata <= {7'($urandom), en};
    @(posedge clk);
    cfg_index <= lcdst_pkg::CFG_IDX_LINE_COMPARE;
    cfg_wdata <= cmp;
    @(posedge clk);
    cfg_index <= lcdst_pkg::CFG_IDX_STAT_IRQ_EN;
    cfg_wdata <= {4'($urandom), irq};
    @(posedge clk);
    cfg_index <= CFG_IDX_UNUSED;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly uniform counts, with weight on the two extremes and on small
  // steps that walk slowly through the mode boundaries within a line.
  function automatic logic [7:0] pick_cycles();
    int unsigned roll;
    logic [7:0]  pick;
    roll = $urandom_range(99);
    if (roll < 8) begin
      pick = 8'd0;
    end else if (roll < 16) begin
      pick = 8'd255;
    end else if (roll < 40) begin
      pick = 8'($urandom_range(15));
    end else begin
      pick = 8'($urandom_range(255));
    end
    return pick;
  endfunction

  initial begin
    logic       en;
    logic [7:0] cmp;
    logic [3:0] irq;
    int         count;

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_elapsed_cycles <= 8'd0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= lcdst_pkg::CFG_IDX_LCD_ENABLE;
    cfg_wdata         <= 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Display switched on straight after reset: the dot counter is still
    // zero, so the first step must leave the mode bits alone. All status
    // interrupt sources are enabled and line 0 matches the compare value.
    program_timing(1'b1, 8'd0, 4'hF);
    send_item(8'd0);
    send_item(8'd255);
    send_item(8'd255);
    send_item(8'd0);
    send_item(8'd1);
    send_item(8'd80);
    send_item(8'd172);
    send_item(8'd128);
    send_item(8'd255);
    send_item(8'd255);
    send_item(8'd254);
    drain_results();

    // Display off: timing is held reset while the coincidence flag is kept
    // and nothing is raised.
    program_timing(1'b0, 8'd0, 4'hF);
    send_item(8'd0);
    send_item(8'd255);
    send_item(8'd7);
    drain_results();

    // Back on with only the vblank and coincidence sources enabled, so the
    // mode change out of the held state must stay quiet.
    program_timing(1'b1, 8'd1, 4'b1010);
    repeat (6) send_item(8'd100);
    drain_results();

    // Random phases. Every phase ends with a full drain before the next
    // register setting, which also pauses the sender with results in flight.
    // Phase 3 keeps the display off; phase 5 runs without any idling.
    for (int ph = 0; ph < 10; ph++) begin
      en = (ph != 3);
      case (ph)
        0:       cmp = 8'd0;
        1:       cmp = 8'd255;
        2:       cmp = lcdst_pkg::VISIBLE_LINES;
        4:       cmp = lcdst_pkg::LAST_LINE;
        7:       cmp = 8'($urandom_range(255));
        default: cmp = 8'($urandom_range(153));
      endcase
      case (ph)
        0, 6:    irq = 4'hF;
        1:       irq = 4'h0;
        default: irq = 4'($urandom_range(15));
      endcase
      count   = en ? 185 : 20;
      gaps_on = (ph != 5);
      program_timing(en, cmp, irq);
      repeat (count) send_item(pick_cycles());
      drain_results();
    end

    gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && status_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/lcdst_pkg.sv
hw/rtl/lcdst_cfg.sv
hw/rtl/lcdst_timing.sv
hw/rtl/lcd_scanline_timing_controller.sv
verif/lcd_scanline_timing_controller_checker.sv
verif/lcd_scanline_timing_controller_tb.sv
